// ===== rtl/dmc_pkg.sv =====
// Shared types and constants for the direct-mapped cache controller.
`default_nettype none
package dmc_pkg;

  localparam int unsigned NUM_LINES_DEF  = 16;
  localparam int unsigned LINE_WORDS_DEF = 4;
  localparam int unsigned MEM_WORDS_DEF  = 65536;

  localparam int unsigned PORT_WORDS = 4;
  localparam int unsigned LADDR_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [3:0] HIT_DELAY_RST = 4'd2;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_STORE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DIRTY  = 2'd1,
    ERR_POLICY = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CFG_HIT_DELAY    = 2'd0,
    CFG_WRITE_POLICY = 2'd1,
    CFG_ALLOC_POLICY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                               wait_res;
    logic [31:0]                        load_data;
    logic [2:0]                         owner_stage;
    err_e                               error_code;
    logic                               lower_read;
    logic                               lower_write;
    logic [LADDR_W-1:0]                 lower_line_addr;
    logic [PORT_WORDS-1:0][31:0]        write_words;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/direct_mapped_cache_controller_top.sv =====
// Top level of the direct-mapped cache controller.
//
// One call (load, store, cancel or no-op) enters on the in channel per item and
// produces exactly one result item on the out channel. A pending request is
// retried by the caller; the answer tells it to wait, or completes the access.
// Lower-level line reads and writes are requested through the result fields,
// and lower_ready with the fill words reports their completion in the same call.
// An accepted item waits in the input register; the result register loads from it
// once the out channel can advance. Throughput: one item per cycle while the
// receiver takes results; the path is one pass through the step logic plus a
// registered read of the line memory at acceptance.
// A stalled receiver holds the result register; the input register still takes
// one more item, then in_ready_o drops until the result is taken.
// Reset clears all line valid and dirty bits, the active request and restores
// hit_delay 2, write-through, no-write-allocate; no clearing pass is needed.
// Configuration writes take effect at the edge where cfg_we_i is high and must
// happen only while no item is in flight.
`default_nettype none
module direct_mapped_cache_controller_top #(
  parameter int unsigned NUM_LINES  = dmc_pkg::NUM_LINES_DEF,
  parameter int unsigned LINE_WORDS = dmc_pkg::LINE_WORDS_DEF,
  parameter int unsigned MEM_WORDS  = dmc_pkg::MEM_WORDS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     func_i,
  input  wire logic signed [31:0]             address_i,
  input  wire logic [2:0]                     requester_i,
  input  wire logic [31:0]                    store_data_i,
  input  wire logic                           lower_ready_i,
  input  wire logic [31:0]                    fill_word_0_i,
  input  wire logic [31:0]                    fill_word_1_i,
  input  wire logic [31:0]                    fill_word_2_i,
  input  wire logic [31:0]                    fill_word_3_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                wait_res_o,
  output logic [31:0]                         load_data_o,
  output logic [2:0]                          owner_stage_o,
  output logic [1:0]                          error_code_o,
  output logic                                lower_read_o,
  output logic                                lower_write_o,
  output logic [dmc_pkg::LADDR_W-1:0]         lower_line_addr_o,
  output logic [31:0]                         write_word_0_o,
  output logic [31:0]                         write_word_1_o,
  output logic [31:0]                         write_word_2_o,
  output logic [31:0]                         write_word_3_o
);
  import dmc_pkg::*;

  localparam int unsigned LOG_L  = $clog2(LINE_WORDS);
  localparam int unsigned LOG_N  = $clog2(NUM_LINES);
  localparam int unsigned ADDR_W = $clog2(MEM_WORDS);
  localparam int unsigned OFF_W  = (LOG_L > 0) ? LOG_L : 1;
  localparam int unsigned IDX_W  = (LOG_N > 0) ? LOG_N : 1;
  localparam int unsigned TAG_W  = (ADDR_W > LOG_L + LOG_N) ? (ADDR_W - LOG_L - LOG_N) : 1;
  localparam int unsigned ROW_W  = 32 * LINE_WORDS;

  typedef logic [LINE_WORDS-1:0][31:0] row_t;

  // configuration
  logic [3:0] hit_delay_q;
  logic       write_pol_q;
  logic       alloc_pol_q;

  // input register
  logic              s1_valid_q;
  func_e             s1_func_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [2:0]        s1_req_q;
  logic [31:0]       s1_sdata_q;
  logic              s1_ready_q;
  row_t              s1_fill_q;

  // active request
  kind_e             act_kind_q, act_kind_d;
  logic [2:0]        act_owner_q, act_owner_d;
  logic [ADDR_W-1:0] act_addr_q, act_addr_d;
  logic [31:0]       act_sword_q, act_sword_d;
  logic              act_miss_q, act_miss_d;
  logic              fetched_q, fetched_d;
  logic [3:0]        cycles_q, cycles_d;
  row_t              fline_q, fline_d;
  logic              fline_we;

  // line state
  logic [NUM_LINES-1:0] line_valid_q;
  logic [NUM_LINES-1:0] line_dirty_q;
  logic [TAG_W-1:0]     line_tag_q [NUM_LINES];

  // result register
  logic out_valid_q;
  res_t out_q, res_d;

  logic advance, step_en, in_acc;
  logic [PORT_WORDS-1:0][31:0] fill_all;
  logic [ADDR_W-1:0]           in_addr;
  logic [IDX_W-1:0]            in_idx;
  logic [ROW_W-1:0]            ram_rdata;
  row_t                        cur_row;

  logic [IDX_W-1:0]  s_idx;
  logic [OFF_W-1:0]  s_off;
  logic [TAG_W-1:0]  s_tag;
  logic [ADDR_W-1:0] s_base;

  logic       mem_we;
  row_t       mem_wrow;
  logic       inst_we, inst_dirty;
  logic       dirty_we, dirty_val;

  assign advance    = !out_valid_q || out_ready_i;
  assign step_en    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  assign fill_all = {fill_word_3_i, fill_word_2_i, fill_word_1_i, fill_word_0_i};
  assign in_addr  = address_i[ADDR_W-1:0];
  assign in_idx   = IDX_W'((in_addr >> LOG_L) & ADDR_W'(NUM_LINES - 1));

  assign s_idx  = IDX_W'((s1_addr_q >> LOG_L) & ADDR_W'(NUM_LINES - 1));
  assign s_off  = OFF_W'(s1_addr_q & ADDR_W'(LINE_WORDS - 1));
  assign s_tag  = TAG_W'(s1_addr_q >> (LOG_L + LOG_N));
  assign s_base = s1_addr_q & ~ADDR_W'(LINE_WORDS - 1);

  assign cur_row = row_t'(ram_rdata);

  dmc_line_ram #(
    .NUM_LINES (NUM_LINES),
    .ROW_W     (ROW_W),
    .IDX_W     (IDX_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we && step_en),
    .waddr_i (s_idx),
    .wdata_i (ROW_W'(mem_wrow)),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    kind_e       kind;
    logic [3:0]  cyc;
    logic        go;
    logic        victim_dirty;
    row_t        wrow;
    logic [2:0]  cur_owner;

    act_kind_d  = act_kind_q;
    act_owner_d = act_owner_q;
    act_addr_d  = act_addr_q;
    act_sword_d = act_sword_q;
    act_miss_d  = act_miss_q;
    fetched_d   = fetched_q;
    cycles_d    = cycles_q;
    fline_d     = fline_q;
    fline_we    = 1'b0;
    mem_we      = 1'b0;
    mem_wrow    = cur_row;
    inst_we     = 1'b0;
    inst_dirty  = 1'b0;
    dirty_we    = 1'b0;
    dirty_val   = 1'b0;
    res_d       = '0;
    kind        = KIND_NONE;
    cyc         = cycles_q;
    go          = 1'b1;
    wrow        = cur_row;
    cur_owner   = act_owner_q;
    victim_dirty = line_valid_q[s_idx] && line_dirty_q[s_idx];

    unique case (s1_func_q)
      FUNC_CANCEL: begin
        act_kind_d = KIND_NONE;
        act_owner_d = '0;
        act_addr_d = '0;
        act_sword_d = '0;
        act_miss_d = 1'b0;
        fetched_d = 1'b0;
        cycles_d = '0;
      end
      FUNC_LOAD, FUNC_STORE: begin
        kind = (s1_func_q == FUNC_LOAD) ? KIND_LOAD : KIND_STORE;
        if (act_kind_q == KIND_NONE) begin
          act_kind_d  = kind;
          act_owner_d = s1_req_q;
          act_addr_d  = s1_addr_q;
          act_sword_d = (kind == KIND_STORE) ? s1_sdata_q : '0;
          act_miss_d  = !(line_valid_q[s_idx] && (line_tag_q[s_idx] == s_tag));
          fetched_d   = 1'b0;
          cycles_d    = (kind == KIND_LOAD && act_miss_d) ? 4'd0 : hit_delay_q;
        end
        cur_owner = act_owner_d;
        cyc = cycles_d;
        if (act_kind_d != kind || act_owner_d != s1_req_q || act_addr_d != s1_addr_q) begin
          res_d.wait_res = 1'b1;
          res_d.owner_stage = cur_owner;
        end else if (kind == KIND_LOAD) begin
          if (act_miss_d && !fetched_d) begin
            res_d.lower_read = 1'b1;
            res_d.lower_line_addr = LADDR_W'(s_base);
            if (!s1_ready_q) begin
              res_d.wait_res = 1'b1;
              res_d.owner_stage = cur_owner;
              go = 1'b0;
            end else begin
              fline_we = 1'b1;
              fline_d = s1_fill_q;
              fetched_d = 1'b1;
              if (victim_dirty && write_pol_q) begin
                res_d.error_code = ERR_DIRTY;
                act_kind_d = KIND_NONE;
                go = 1'b0;
              end else begin
                inst_we = 1'b1;
                mem_we = 1'b1;
                mem_wrow = s1_fill_q;
                wrow = s1_fill_q;
                cyc = hit_delay_q;
                cycles_d = hit_delay_q;
              end
            end
          end
          if (go) begin
            if (cyc != 4'd0) begin
              cycles_d = cyc - 4'd1;
              if (cycles_d != 4'd0) begin
                res_d.wait_res = 1'b1;
                res_d.owner_stage = cur_owner;
                go = 1'b0;
              end
            end
            if (go) begin
              res_d.load_data = wrow[s_off];
              act_kind_d = KIND_NONE;
            end
          end
        end else begin
          if (!act_miss_d) begin
            if (cyc != 4'd0) begin
              cycles_d = cyc - 4'd1;
              res_d.wait_res = 1'b1;
              res_d.owner_stage = cur_owner;
            end else begin
              wrow[s_off] = act_sword_d;
              mem_we = 1'b1;
              mem_wrow = wrow;
              if (!write_pol_q) begin
                res_d.lower_write = 1'b1;
                res_d.lower_line_addr = LADDR_W'(s_base);
                for (int i = 0; i < LINE_WORDS; i++) res_d.write_words[i] = wrow[i];
                if (!s1_ready_q) begin
                  res_d.wait_res = 1'b1;
                  res_d.owner_stage = cur_owner;
                end else begin
                  dirty_we = 1'b1;
                  act_kind_d = KIND_NONE;
                end
              end else begin
                dirty_we = 1'b1;
                dirty_val = 1'b1;
                act_kind_d = KIND_NONE;
              end
            end
          end else if (!write_pol_q && !alloc_pol_q) begin
            res_d.lower_line_addr = LADDR_W'(s_base);
            if (!fetched_d) begin
              res_d.lower_read = 1'b1;
              res_d.wait_res = 1'b1;
              res_d.owner_stage = cur_owner;
              if (s1_ready_q) begin
                fline_we = 1'b1;
                fline_d = s1_fill_q;
                fline_d[s_off] = act_sword_d;
                fetched_d = 1'b1;
              end
            end else begin
              res_d.lower_write = 1'b1;
              for (int i = 0; i < LINE_WORDS; i++) res_d.write_words[i] = fline_q[i];
              if (!s1_ready_q) begin
                res_d.wait_res = 1'b1;
                res_d.owner_stage = cur_owner;
              end else begin
                act_kind_d = KIND_NONE;
              end
            end
          end else if (write_pol_q && alloc_pol_q) begin
            if (!fetched_d) begin
              res_d.lower_read = 1'b1;
              res_d.lower_line_addr = LADDR_W'(s_base);
              if (!s1_ready_q) begin
                res_d.wait_res = 1'b1;
                res_d.owner_stage = cur_owner;
                go = 1'b0;
              end else begin
                fline_we = 1'b1;
                fline_d = s1_fill_q;
                fline_d[s_off] = act_sword_d;
                fetched_d = 1'b1;
                if (victim_dirty) begin
                  res_d.error_code = ERR_DIRTY;
                  act_kind_d = KIND_NONE;
                  go = 1'b0;
                end else begin
                  inst_we = 1'b1;
                  inst_dirty = 1'b1;
                  mem_we = 1'b1;
                  mem_wrow = fline_d;
                end
              end
            end
            if (go) begin
              if (cyc != 4'd0) begin
                cycles_d = cyc - 4'd1;
                res_d.wait_res = 1'b1;
                res_d.owner_stage = cur_owner;
              end else begin
                act_kind_d = KIND_NONE;
              end
            end
          end else begin
            res_d.error_code = ERR_POLICY;
            act_kind_d = KIND_NONE;
          end
        end
        if (act_kind_d == KIND_NONE) begin
          act_owner_d = '0;
          act_addr_d = '0;
          act_sword_d = '0;
          act_miss_d = 1'b0;
          fetched_d = 1'b0;
          cycles_d = '0;
        end
      end
      FUNC_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_delay_q  <= HIT_DELAY_RST;
      write_pol_q  <= 1'b0;
      alloc_pol_q  <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      act_kind_q   <= KIND_NONE;
      act_owner_q  <= '0;
      act_addr_q   <= '0;
      act_sword_q  <= '0;
      act_miss_q   <= 1'b0;
      fetched_q    <= 1'b0;
      cycles_q     <= '0;
      line_valid_q <= '0;
      line_dirty_q <= '0;
    end else begin
      if (cfg_we_i) begin
        priority case (cfg_index_i)
          CFG_HIT_DELAY:    hit_delay_q <= cfg_data_i[3:0];
          CFG_WRITE_POLICY: write_pol_q <= cfg_data_i[0];
          CFG_ALLOC_POLICY: alloc_pol_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (step_en) begin
        act_kind_q  <= act_kind_d;
        act_owner_q <= act_owner_d;
        act_addr_q  <= act_addr_d;
        act_sword_q <= act_sword_d;
        act_miss_q  <= act_miss_d;
        fetched_q   <= fetched_d;
        cycles_q    <= cycles_d;
        if (inst_we) begin
          line_valid_q[s_idx] <= 1'b1;
          line_dirty_q[s_idx] <= inst_dirty;
        end else if (dirty_we) begin
          line_dirty_q[s_idx] <= dirty_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q  <= func_e'(func_i);
      s1_addr_q  <= in_addr;
      s1_req_q   <= requester_i;
      s1_sdata_q <= store_data_i;
      s1_ready_q <= lower_ready_i;
      for (int i = 0; i < LINE_WORDS; i++) s1_fill_q[i] <= fill_all[i];
    end
    if (step_en) begin
      out_q <= res_d;
      if (fline_we) begin
        fline_q <= fline_d;
      end
      if (inst_we) begin
        line_tag_q[s_idx] <= s_tag;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign wait_res_o        = out_q.wait_res;
  assign load_data_o       = out_q.load_data;
  assign owner_stage_o     = out_q.owner_stage;
  assign error_code_o      = out_q.error_code;
  assign lower_read_o      = out_q.lower_read;
  assign lower_write_o     = out_q.lower_write;
  assign lower_line_addr_o = out_q.lower_line_addr;
  assign write_word_0_o    = out_q.write_words[0];
  assign write_word_1_o    = out_q.write_words[1];
  assign write_word_2_o    = out_q.write_words[2];
  assign write_word_3_o    = out_q.write_words[3];

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.error_code != ERR_NONE) |-> !out_q.wait_res)
    else $error("error result marked as wait");

  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.lower_read && out_q.lower_write))
    else $error("line read and write requested together");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_kind_q == KIND_NONE) |-> (!fetched_q && (cycles_q == 4'd0) && !act_miss_q))
    else $error("idle controller holds request state");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.load_data != 32'd0) |-> !out_q.wait_res && !out_q.lower_write)
    else $error("load data on an incomplete result");

endmodule
`default_nettype wire

// ===== rtl/dmc_line_ram.sv =====
// Line data memory: one row per line, one write port, registered read with write bypass.
`default_nettype none
module dmc_line_ram #(
  parameter int unsigned NUM_LINES = dmc_pkg::NUM_LINES_DEF,
  parameter int unsigned ROW_W     = 32 * dmc_pkg::LINE_WORDS_DEF,
  parameter int unsigned IDX_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [ROW_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [ROW_W-1:0] rdata_o
);
  import dmc_pkg::*;

  logic [ROW_W-1:0] mem [NUM_LINES];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the direct-mapped cache controller: directed calls, then random call streams.
`timescale 1ns / 100ps
module testbench;
  import dmc_pkg::*;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      raw;
    logic [2:0]       req;
    logic [31:0]      sdata;
    logic             rdy;
    logic [3:0][31:0] fill;
  } call_t;

  typedef struct packed {
    logic             w;
    logic [31:0]      data;
    logic [2:0]       own;
    logic [1:0]       err;
    logic             rd;
    logic             wr;
    logic [15:0]      la;
    logic [3:0][31:0] ww;
  } cache_res_t;

  typedef struct packed {
    call_t      c;
    logic       typed;
    cache_res_t e;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = FUNC_NOP;
  logic signed [31:0] address_i = '0;
  logic [2:0] requester_i = '0;
  logic [31:0] store_data_i = '0;
  logic lower_ready_i = 1'b0;
  logic [31:0] fill_word_0_i = '0, fill_word_1_i = '0, fill_word_2_i = '0, fill_word_3_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic wait_res_o, lower_read_o, lower_write_o;
  logic [31:0] load_data_o;
  logic [2:0] owner_stage_o;
  logic [1:0] error_code_o;
  logic [15:0] lower_line_addr_o;
  logic [31:0] write_word_0_o, write_word_1_o, write_word_2_o, write_word_3_o;

  direct_mapped_cache_controller_top dut (.*);

  always #2 clk_i = ~clk_i;

  // cache image and pending request
  logic        lv[16], ldirty[16];
  logic [9:0]  ltag[16];
  logic [31:0] lwords[64];
  kind_e       act_kind;
  logic [2:0]  act_owner;
  logic [15:0] act_addr;
  logic [31:0] act_word;
  logic        act_miss, got_line;
  logic [3:0]  delay_left;
  logic [31:0] line_buf[4];
  logic [3:0]  hit_delay;
  logic        wr_back, wr_alloc;

  cache_res_t  expected_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          hold_left = 0;
  bit          held = 0;

  function automatic void drop_request();
    act_kind = KIND_NONE; act_owner = '0; act_addr = '0; act_word = '0;
    act_miss = 0; got_line = 0; delay_left = '0;
  endfunction

  function automatic void hold_wait(inout cache_res_t r);
    r.w = 1; r.own = act_owner;
  endfunction

  function automatic void grab_fill(call_t c);
    for (int i = 0; i < 4; i++) line_buf[i] = c.fill[i];
    got_line = 1;
  endfunction

  function automatic void fill_line(logic [3:0] ix, logic [9:0] tg, logic d);
    lv[ix] = 1; ldirty[ix] = d; ltag[ix] = tg;
    for (int i = 0; i < 4; i++) lwords[{ix, i[1:0]}] = line_buf[i];
  endfunction

  function automatic cache_res_t load_call(call_t c);
    cache_res_t r;
    logic [3:0] ix;
    r = '0; ix = act_addr[5:2];
    if (act_miss && !got_line) begin
      r.rd = 1; r.la = {act_addr[15:2], 2'b00};
      if (!c.rdy) begin
        hold_wait(r); return r;
      end
      grab_fill(c);
      if (lv[ix] && ldirty[ix] && wr_back) begin
        r.err = ERR_DIRTY; drop_request(); return r;
      end
      fill_line(ix, act_addr[15:6], 0);
      delay_left = hit_delay;
    end
    if (delay_left > 0) begin
      delay_left--;
      if (delay_left > 0) begin
        hold_wait(r); return r;
      end
    end
    r.data = lwords[{ix, act_addr[1:0]}];
    drop_request();
    return r;
  endfunction

  function automatic cache_res_t store_call(call_t c);
    cache_res_t r;
    logic [3:0] ix;
    logic [1:0] of;
    r = '0; ix = act_addr[5:2]; of = act_addr[1:0];
    if (!act_miss) begin
      if (delay_left > 0) begin
        delay_left--; hold_wait(r); return r;
      end
      lwords[{ix, of}] = act_word;
      if (!wr_back) begin
        r.wr = 1; r.la = {act_addr[15:2], 2'b00};
        for (int i = 0; i < 4; i++) r.ww[i] = lwords[{ix, i[1:0]}];
        if (!c.rdy) begin
          hold_wait(r); return r;
        end
        ldirty[ix] = 0;
      end else ldirty[ix] = 1;
      drop_request();
      return r;
    end
    if (!wr_back && !wr_alloc) begin
      if (!got_line) begin
        r.rd = 1; r.la = {act_addr[15:2], 2'b00};
        if (!c.rdy) begin
          hold_wait(r); return r;
        end
        grab_fill(c);
        line_buf[of] = act_word;
        hold_wait(r);
        return r;
      end
      r.wr = 1; r.la = {act_addr[15:2], 2'b00};
      for (int i = 0; i < 4; i++) r.ww[i] = line_buf[i];
      if (!c.rdy) begin
        hold_wait(r); return r;
      end
      drop_request();
      return r;
    end
    if (wr_back && wr_alloc) begin
      if (!got_line) begin
        r.rd = 1; r.la = {act_addr[15:2], 2'b00};
        if (!c.rdy) begin
          hold_wait(r); return r;
        end
        grab_fill(c);
        line_buf[of] = act_word;
        if (lv[ix] && ldirty[ix]) begin
          r.err = ERR_DIRTY; drop_request(); return r;
        end
        fill_line(ix, act_addr[15:6], 1);
      end
      if (delay_left > 0) begin
        delay_left--; hold_wait(r); return r;
      end
      drop_request();
      return r;
    end
    r.err = ERR_POLICY;
    drop_request();
    return r;
  endfunction

  function automatic cache_res_t cache_step(call_t c);
    cache_res_t r;
    logic [15:0] a;
    kind_e k;
    r = '0; a = c.raw[15:0];
    if (c.func == FUNC_CANCEL) drop_request();
    else if (c.func != FUNC_NOP) begin
      k = (c.func == FUNC_LOAD) ? KIND_LOAD : KIND_STORE;
      if (act_kind == KIND_NONE) begin
        act_kind = k; act_owner = c.req; act_addr = a;
        act_word = (k == KIND_STORE) ? c.sdata : '0;
        act_miss = !(lv[a[5:2]] && ltag[a[5:2]] == a[15:6]);
        got_line = 0;
        delay_left = (k == KIND_LOAD && act_miss) ? 4'd0 : hit_delay;
      end
      if (act_kind != k || act_owner != c.req || act_addr != a) hold_wait(r);
      else if (k == KIND_LOAD) r = load_call(c);
      else r = store_call(c);
    end
    return r;
  endfunction

  task automatic send_call(call_t c, bit idle_ok);
    bit taken;
    if (idle_ok && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= c.func; address_i <= c.raw; requester_i <= c.req; store_data_i <= c.sdata;
    lower_ready_i <= c.rdy;
    fill_word_0_i <= c.fill[0]; fill_word_1_i <= c.fill[1];
    fill_word_2_i <= c.fill[2]; fill_word_3_i <= c.fill[3];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic settle_and_config(logic [3:0] hd, logic wb, logic wa);
    in_valid_i <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= CFG_HIT_DELAY; cfg_data_i <= hd;
    @(posedge clk_i);
    cfg_index_i <= CFG_WRITE_POLICY; cfg_data_i <= {3'b000, wb};
    @(posedge clk_i);
    cfg_index_i <= CFG_ALLOC_POLICY; cfg_data_i <= {3'b000, wa};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hit_delay = hd; wr_back = wb; wr_alloc = wa;
  endtask

  function automatic logic [31:0] pick_addr();
    logic [9:0] tg;
    case ($urandom_range(3))
      0: tg = '0;
      1: tg = 10'd1;
      2: tg = '1;
      default: tg = 10'($urandom);
    endcase
    return {16'($urandom), tg, 4'($urandom), 2'($urandom)};
  endfunction

  function automatic call_t random_call(call_t last);
    call_t c;
    int p;
    c.raw = pick_addr(); c.req = 3'($urandom); c.sdata = $urandom;
    c.rdy = 1'($urandom_range(1)); c.fill = {$urandom, $urandom, $urandom, $urandom};
    p = $urandom_range(99);
    if (act_kind != KIND_NONE) begin
      if (p < 80) begin
        c.func = last.func; c.req = last.req;
        c.raw = {16'($urandom), last.raw[15:0]};
      end else if (p < 88) begin
        c.func = last.func; c.raw = last.raw; c.req = last.req + 3'($urandom_range(1, 7));
      end else if (p < 93) c.func = FUNC_CANCEL;
      else if (p < 96) c.func = FUNC_NOP;
      else c.func = 2'($urandom_range(1));
    end else begin
      if (p < 45) c.func = FUNC_LOAD;
      else if (p < 90) c.func = FUNC_STORE;
      else if (p < 95) c.func = FUNC_CANCEL;
      else c.func = FUNC_NOP;
    end
    return c;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cache_res_t got, want;
    if (out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      got = {wait_res_o, load_data_o, owner_stage_o, error_code_o, lower_read_o,
             lower_write_o, lower_line_addr_o, write_word_3_o, write_word_2_o,
             write_word_1_o, write_word_0_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got.w !== want.w || got.data !== want.data || got.own !== want.own ||
            got.err !== want.err || got.rd !== want.rd || got.wr !== want.wr ||
            got.la !== want.la || got.ww !== want.ww) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, one calm stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (results_seen >= 150 && !held) begin
      held <= 1'b1;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else if (results_seen >= 800 && results_seen < 1100) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 28);
    end
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t rows[12];
    call_t c, last;
    cache_res_t r;
    logic [3:0] hd_set[10] = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd0, 4'd15, 4'd3, 4'd3, 4'd5, 4'd1};
    logic wb_set[10] = '{0, 0, 0, 1, 1, 1, 0, 1, 0, 1};
    logic wa_set[10] = '{0, 0, 0, 1, 1, 1, 1, 0, 0, 1};
    for (int i = 0; i < 16; i++) begin
      lv[i] = 0; ldirty[i] = 0; ltag[i] = '0;
    end
    for (int i = 0; i < 64; i++) lwords[i] = '0;
    for (int i = 0; i < 4; i++) line_buf[i] = '0;
    drop_request();
    hit_delay = HIT_DELAY_RST; wr_back = 0; wr_alloc = 0;

    rows[0] = '{c: '{FUNC_LOAD, 32'h0, 3'd1, 32'h0, 1'b0, '0}, typed: 1,
                e: '{w: 1'b1, own: 3'd1, rd: 1'b1, default: '0}};
    rows[1] = '{c: '{FUNC_LOAD, 32'h0, 3'd2, 32'h0, 1'b0, '0}, typed: 1,
                e: '{w: 1'b1, own: 3'd1, default: '0}};
    rows[2] = '{c: '{FUNC_LOAD, 32'h0, 3'd1, 32'h0, 1'b1,
                {32'hDDDD_0003, 32'hCCCC_0002, 32'hBBBB_0001, 32'hAAAA_0000}},
                typed: 0, e: '0};
    rows[3] = '{c: '{FUNC_LOAD, 32'h0, 3'd1, 32'h0, 1'b0, '0}, typed: 0, e: '0};
    rows[4] = '{c: '{FUNC_NOP, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b1, '1}, typed: 1,
                e: '0};
    rows[5] = '{c: '{FUNC_LOAD, 32'h8000_0001, 3'd3, 32'h0, 1'b0, '0}, typed: 0, e: '0};
    rows[6] = '{c: '{FUNC_CANCEL, 32'h0, 3'd0, 32'h0, 1'b0, '0}, typed: 1, e: '0};
    rows[7] = '{c: '{FUNC_STORE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b0, '0},
                typed: 0, e: '0};
    rows[8] = '{c: '{FUNC_STORE, 32'h7FFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b1,
                {32'h4, 32'h3, 32'h2, 32'h1}}, typed: 0, e: '0};
    rows[9] = '{c: '{FUNC_STORE, 32'hFFFF_FFFF, 3'd7, 32'h0, 1'b0, '0}, typed: 0, e: '0};
    rows[10] = '{c: '{FUNC_STORE, 32'hFFFF_FFFF, 3'd7, 32'h0, 1'b1, '0}, typed: 0, e: '0};
    rows[11] = '{c: '{FUNC_STORE, 32'h2, 3'd0, 32'h1234_5678, 1'b0, '0}, typed: 0, e: '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      r = cache_step(rows[i].c);
      expected_q.push_back(rows[i].typed ? rows[i].e : r);
      send_call(rows[i].c, 0);
    end
    // finish the store hit with a completing write below
    c = rows[11].c;
    while (act_kind != KIND_NONE) begin
      c.rdy = 1'($urandom_range(1));
      expected_q.push_back(cache_step(c));
      send_call(c, 1);
    end

    for (int ph = 0; ph < 10; ph++) begin
      settle_and_config(hd_set[ph], wb_set[ph], wa_set[ph]);
      last = '0;
      for (int n = 0; n < 195; n++) begin
        c = random_call(last);
        last = c;
        expected_q.push_back(cache_step(c));
        send_call(c, !(items_sent >= 800 && items_sent < 1100));
      end
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
